>>> rtl/sidfr_pkg.sv
`timescale 1ns / 1ps

package sidfr_pkg;

    // Frame constants
    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [8:0] SUM_MOD   = 9'd255;

    // Token queue between parser and checksum stage (depth must be a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Config register indexes
    localparam logic CFG_OWN_ID  = 1'b0;
    localparam logic CFG_PEER_ID = 1'b1;

    typedef enum logic [2:0] {
        PH_SYNC_A,
        PH_SYNC_B,
        PH_SENDER,
        PH_RECEIVER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    // What the back end does with a byte
    typedef enum logic [2:0] {
        K_IDLE,       // outside a frame, no sum update
        K_START,      // first sync byte, sum restarts
        K_ADD,        // header byte, added to sum
        K_PAY,        // payload byte
        K_PAY_LAST,   // last payload byte, sum reduced mod 255
        K_CHECK,      // checksum byte
        K_ERR_SND,    // sender id mismatch
        K_ERR_RCV     // receiver id mismatch
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_SENDER,
        ERR_RECEIVER,
        ERR_CHECKSUM
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [15:0] length;
    } tok_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic        frame_good;
        err_t        error_code;
        logic [15:0] frame_length;
    } res_t;

endpackage

>>> rtl/sync_id_length_frame_receiver_core.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+--------------------------------------------------
// s_       | in  | s_valid / s_ready  | s_rx_byte[7:0]
// m_       | out | m_valid / m_ready  | m_payload_valid, m_payload_byte[7:0],
//          |     |                    | m_payload_last, m_frame_good, m_error_code[1:0],
//          |     |                    | m_frame_length[15:0]
// cfg_     | in  | cfg_we (no stall)  | cfg_index[0], cfg_wdata[7:0]
//
// One beat in, one beat out; sustains one byte per cycle while m_ready stays high.
// Each accepted beat's token is written into the queue on the accepting edge, and the
// output register loads it from the queue once the result channel can take it.
// The parser FSM updates its state on the accepting edge; a two-entry token queue
// decouples it from the checksum stage, so either side stalls on its own.
// aresetn is synchronous, active low; clears parser state, queue, sum and m_valid.
// Config registers reset to zero; the user must write them only while the block is idle (not enforced).

module sync_id_length_frame_receiver_core import sidfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic        m_payload_last,
    output logic        m_frame_good,
    output logic [1:0]  m_error_code,
    output logic [15:0] m_frame_length,
    // config write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);

    logic [7:0] own_id_reg;
    logic [7:0] peer_id_reg;

    // front -> queue
    logic tok_valid, tok_ready;
    tok_t tok;

    // queue -> back
    logic q_valid, q_ready;
    tok_t q_tok;

    res_t res;

    // Config registers: own id checked against the receiver id byte,
    // peer id against the sender id byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg  <= 8'd0;
            peer_id_reg <= 8'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_OWN_ID:  own_id_reg  <= cfg_wdata;
                CFG_PEER_ID: peer_id_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Parser: sync hunt, id checks, length and payload count; tags each byte.
    sidfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .rx_byte   (s_rx_byte),
        .own_id    (own_id_reg),
        .peer_id   (peer_id_reg),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

    // Short token queue so the parser keeps taking beats while m_ stalls, until the queue is full.
    sidfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tok_valid),
        .in_ready  (tok_ready),
        .in_tok    (tok),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_tok   (q_tok)
    );

    // Checksum accumulation, mod-255 reduction and result formatting.
    sidfr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_tok   (q_tok),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (res)
    );

    assign m_payload_valid = res.payload_valid;
    assign m_payload_byte  = res.payload_byte;
    assign m_payload_last  = res.payload_last;
    assign m_frame_good    = res.frame_good;
    assign m_error_code    = res.error_code;
    assign m_frame_length  = res.frame_length;

endmodule

>>> rtl/sidfr_front.sv
`timescale 1ns / 1ps

module sidfr_front import sidfr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] rx_byte,
    input  logic [7:0] own_id,
    input  logic [7:0] peer_id,
    output logic       tok_valid,
    input  logic       tok_ready,
    output tok_t       tok
);

    phase_t      phase_reg,  phase_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg,  count_next;
    logic [15:0] count_inc;
    logic        accept;
    logic        at_last;

    assign s_ready   = tok_ready;
    assign tok_valid = s_valid;
    assign accept    = s_valid && tok_ready;
    assign count_inc = count_reg + 16'd1;
    assign at_last   = (count_inc >= length_reg);

    // next state
    always_comb begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_SYNC_A: begin
                    if (rx_byte == SYNC_BYTE) begin
                        phase_next  = PH_SYNC_B;
                        length_next = 16'd0;
                        count_next  = 16'd0;
                    end
                end
                PH_SYNC_B: begin
                    phase_next = (rx_byte == SYNC_BYTE) ? PH_SENDER : PH_SYNC_A;
                end
                PH_SENDER: begin
                    phase_next = (rx_byte == peer_id) ? PH_RECEIVER : PH_SYNC_A;
                end
                PH_RECEIVER: begin
                    phase_next = (rx_byte == own_id) ? PH_LEN_HI : PH_SYNC_A;
                end
                PH_LEN_HI: begin
                    length_next = {rx_byte, 8'h00};
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    length_next = {length_reg[15:8], rx_byte};
                    phase_next  = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    count_next = count_inc;
                    if (at_last) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    phase_next = PH_SYNC_A;
                end
                default: begin
                    phase_next = PH_SYNC_A;
                end
            endcase
        end
    end

    // classify the byte for the back end
    always_comb begin
        tok.kind   = K_IDLE;
        tok.data   = rx_byte;
        tok.length = length_reg;
        unique case (phase_reg)
            PH_SYNC_A:   tok.kind = (rx_byte == SYNC_BYTE) ? K_START : K_IDLE;
            PH_SYNC_B:   tok.kind = (rx_byte == SYNC_BYTE) ? K_ADD : K_IDLE;
            PH_SENDER:   tok.kind = (rx_byte == peer_id) ? K_ADD : K_ERR_SND;
            PH_RECEIVER: tok.kind = (rx_byte == own_id) ? K_ADD : K_ERR_RCV;
            PH_LEN_HI:   tok.kind = K_ADD;
            PH_LEN_LO:   tok.kind = K_ADD;
            PH_PAYLOAD:  tok.kind = at_last ? K_PAY_LAST : K_PAY;
            PH_CHECK:    tok.kind = K_CHECK;
            default:     tok.kind = K_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SYNC_A;
            length_reg <= 16'd0;
            count_reg  <= 16'd0;
        end else begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    // checksum phase is only entered from the payload
    a_check_after_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CHECK) && ($past(phase_reg) != PH_CHECK)
        |-> $past(phase_reg) == PH_PAYLOAD)
        else $error("check phase not entered from payload");

    // payload count never passes the declared length while in payload
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) && (length_reg != 16'd0) |-> count_reg < length_reg)
        else $error("payload count overran declared length");
`endif

endmodule

>>> rtl/sidfr_queue.sv
`timescale 1ns / 1ps

module sidfr_queue import sidfr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  tok_t in_tok,
    output logic out_valid,
    input  logic out_ready,
    output tok_t out_tok
);

    tok_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push, pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_tok   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

>>> rtl/sidfr_back.sv
`timescale 1ns / 1ps

module sidfr_back import sidfr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_ready,
    input  tok_t q_tok,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_res
);

    logic        m_valid_reg;
    res_t        res_reg, res_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] sum_add;
    logic [8:0]  fold_s, fold_r1, fold_r2;

    assign q_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

    // 16-bit sum mod 255: 256 == 1 (mod 255), so fold high byte onto low
    always_comb begin
        sum_add = sum_reg + {8'h00, q_tok.data};
        fold_s  = {1'b0, sum_add[15:8]} + {1'b0, sum_add[7:0]};
        fold_r1 = (fold_s >= SUM_MOD) ? fold_s - SUM_MOD : fold_s;
        fold_r2 = (fold_r1 >= SUM_MOD) ? fold_r1 - SUM_MOD : fold_r1;
    end

    always_comb begin
        res_next               = '0;
        res_next.error_code    = ERR_NONE;
        sum_next               = sum_reg;
        unique case (q_tok.kind)
            K_IDLE: begin
            end
            K_START: begin
                sum_next = {8'h00, SYNC_BYTE};
            end
            K_ADD: begin
                sum_next = sum_add;
            end
            K_PAY: begin
                sum_next               = sum_add;
                res_next.payload_valid = 1'b1;
                res_next.payload_byte  = q_tok.data;
            end
            K_PAY_LAST: begin
                sum_next               = {8'h00, fold_r2[7:0]};
                res_next.payload_valid = 1'b1;
                res_next.payload_byte  = q_tok.data;
                res_next.payload_last  = 1'b1;
            end
            K_CHECK: begin
                res_next.frame_length = q_tok.length;
                if (q_tok.data == sum_reg[7:0]) begin
                    res_next.frame_good = 1'b1;
                    sum_next            = 16'd0;
                end else begin
                    res_next.error_code = ERR_CHECKSUM;
                end
            end
            K_ERR_SND: begin
                res_next.error_code = ERR_SENDER;
            end
            K_ERR_RCV: begin
                res_next.error_code = ERR_RECEIVER;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sum_reg     <= 16'd0;
        end else if (q_ready) begin
            m_valid_reg <= q_valid;
            if (q_valid) begin
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ready && q_valid) begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTH
    a_good_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.frame_good |-> res_reg.error_code == ERR_NONE)
        else $error("good frame flagged with error");

    a_last_is_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.payload_last |-> res_reg.payload_valid)
        else $error("last flag without payload");
`endif

endmodule
